### rtl/ies_pkg.sv
// Shared types and constants for the image error statistics block.
// Used by every module under rtl/; depends on nothing.
`default_nettype none

package ies_pkg;

  // Raster limits and counter widths
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CMP_W      = 14;

  // Accumulator widths
  localparam int CNT_W  = 25;
  localparam int RSUM_W = 32;
  localparam int SQ_W   = 40;
  localparam int DSUM_W = 34;
  localparam int DABS_W = 32;
  localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(24'hFFFFFF) + CNT_W'(1);

  // Configuration port
  localparam int CFG_W      = 13;
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_WIDTH = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_WIN_LEFT    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_WIN_TOP     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_WIN_RIGHT   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_WIN_BOTTOM  = 3'd4;

  // Frame queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Back end arithmetic
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int HALF_W = SQ_W / 2;
  localparam int NUM_W  = 64;
  localparam int DEN_W  = 49;
  localparam int QUOT_W = 24;
  localparam int FRAC_W = 8;
  localparam int STEP_W = $clog2(QUOT_W);

  typedef struct packed {
    logic [7:0] ref_pixel;
    logic [7:0] test_pixel;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [23:0] mse_q8;
    logic [21:0] ref_variance_q8;
    logic [23:0] diff_variance_q8;
    logic        diff_variance_zero;
    logic        empty_window;
    logic [24:0] pixel_count;
  } out_item_t;

  // Sums of one finished frame
  typedef struct packed {
    logic [CNT_W-1:0]         count;
    logic [RSUM_W-1:0]        ref_sum;
    logic [SQ_W-1:0]          ref_square_sum;
    logic signed [DSUM_W-1:0] diff_sum;
    logic [SQ_W-1:0]          diff_square_sum;
  } frame_stats_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MSE_SET,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_SQ,
    ST_MUL_NN,
    ST_DEN,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_STORE,
    ST_OUT
  } back_state_t;

  typedef enum logic [1:0] {
    PASS_MSE,
    PASS_REF,
    PASS_DIFF
  } pass_t;

endpackage

`default_nettype wire

### rtl/image_error_statistics_top.sv
// Top level of the image error statistics block.
// Depends on ies_pkg, ies_front, ies_queue and ies_back.
`default_nettype none

// Takes one (reference, test) pixel pair per clock in raster order and, on the
// pixel flagged frame_end, returns one transaction with the windowed MSE,
// reference variance and difference variance in unsigned Q8, the pixel count
// and the zero-variance and empty-window flags. Pixels are accepted every
// cycle while the frame queue has room; the front end accumulates one pixel
// per accepted clock with 8x8 squares and 40-bit adds. Each finished frame
// goes into a two-entry queue, and the back end turns it into a result: one
// shared 32x32 multiplier builds n*S2 - S1*S1 and n*n in four products, and
// a radix-2 divider computes each of the three quotients. Input stalls only
// while two frame records wait in the queue, so a run of short frames can
// throttle the input. Write the cfg_ registers only while the block is
// idle; indexes above the last register are ignored.
module image_error_statistics_top
  import ies_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  logic         push;
  logic         push_ready;
  frame_stats_t push_data;
  logic         pop_valid;
  logic         pop;
  frame_stats_t pop_data;

  ies_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .stats_valid (push),
    .stats_ready (push_ready),
    .stats       (push_data)
  );

  ies_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  ies_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .stats_valid (pop_valid),
    .stats       (pop_data),
    .stats_pop   (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

### rtl/ies_front.sv
// Front end: configuration registers, raster counters and window accumulators.
// Depends on ies_pkg; hands one frame_stats_t per frame to the frame queue.
`default_nettype none

module ies_front
  import ies_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  stats_valid,
  input  logic                  stats_ready,
  output frame_stats_t          stats
);

  logic [12:0]              frame_width_r;
  logic [11:0]              win_left_r;
  logic [11:0]              win_top_r;
  logic [12:0]              win_right_r;
  logic [12:0]              win_bottom_r;

  logic [COL_W-1:0]         column_r;
  logic [ROW_W-1:0]         row_r;
  logic [CNT_W-1:0]         count_r;
  logic [RSUM_W-1:0]        ref_sum_r;
  logic [SQ_W-1:0]          ref_sq_r;
  logic signed [DSUM_W-1:0] diff_sum_r;
  logic [SQ_W-1:0]          diff_sq_r;

  logic [COL_W-1:0]         column_nxt;
  logic [ROW_W-1:0]         row_nxt;
  logic                     accept;
  logic                     in_window;
  logic                     take;
  logic signed [8:0]        diff;
  logic [7:0]               diff_abs;
  logic [15:0]              ref_sq;
  logic [15:0]              diff_sq;
  logic [12:0]              width_eff;
  logic                     line_end;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= 13'(MAX_WIDTH);
      win_left_r    <= '0;
      win_top_r     <= '0;
      win_right_r   <= '1;
      win_bottom_r  <= '1;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FRAME_WIDTH: frame_width_r <= cfg_wdata;
        CFG_WIN_LEFT:    win_left_r    <= cfg_wdata[11:0];
        CFG_WIN_TOP:     win_top_r     <= cfg_wdata[11:0];
        CFG_WIN_RIGHT:   win_right_r   <= cfg_wdata;
        CFG_WIN_BOTTOM:  win_bottom_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stall only when no queue slot is free for a finished frame
  assign in_ready = stats_ready;
  assign accept   = in_valid && in_ready;

  // Window test; a negative right or bottom bound runs to the frame edge
  assign in_window = (CMP_W'(column_r) >= CMP_W'(win_left_r))
                  && (CMP_W'(row_r) >= CMP_W'(win_top_r))
                  && (win_right_r[12] || (CMP_W'(column_r) <= CMP_W'(win_right_r[11:0])))
                  && (win_bottom_r[12] || (CMP_W'(row_r) <= CMP_W'(win_bottom_r[11:0])));
  assign take = in_window && (count_r < COUNT_CAP);

  // Per-pixel terms
  assign diff     = $signed({1'b0, in_data.test_pixel}) - $signed({1'b0, in_data.ref_pixel});
  assign diff_abs = diff[8] ? 8'(-diff) : diff[7:0];
  assign ref_sq   = 16'(in_data.ref_pixel) * 16'(in_data.ref_pixel);
  assign diff_sq  = 16'(diff_abs) * 16'(diff_abs);

  // Updated sums, which also form the frame record on the last pixel
  always_comb begin
    stats = '0;
    stats.count           = count_r + CNT_W'(take);
    stats.ref_sum         = take ? ref_sum_r + RSUM_W'(in_data.ref_pixel) : ref_sum_r;
    stats.ref_square_sum  = take ? ref_sq_r + SQ_W'(ref_sq) : ref_sq_r;
    stats.diff_sum        = take ? diff_sum_r + DSUM_W'(diff) : diff_sum_r;
    stats.diff_square_sum = take ? diff_sq_r + SQ_W'(diff_sq) : diff_sq_r;
  end

  assign stats_valid = accept && in_data.frame_end;

  // Clamp the line length to one through MAX_WIDTH
  always_comb begin
    priority if (frame_width_r == '0) begin
      width_eff = 13'd1;
    end else if (frame_width_r > 13'(MAX_WIDTH)) begin
      width_eff = 13'(MAX_WIDTH);
    end else begin
      width_eff = frame_width_r;
    end
  end

  // Advance column and row; row saturates at the last row
  assign line_end = (CMP_W'(column_r) + CMP_W'(1)) >= CMP_W'(width_eff);

  always_comb begin
    column_nxt = column_r + COL_W'(1);
    row_nxt    = row_r;
    if (line_end) begin
      column_nxt = '0;
      if (row_r != ROW_W'(MAX_HEIGHT - 1)) begin
        row_nxt = row_r + ROW_W'(1);
      end
    end
  end

  // Accumulate, or clear after the last pixel of a frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r   <= '0;
      row_r      <= '0;
      count_r    <= '0;
      ref_sum_r  <= '0;
      ref_sq_r   <= '0;
      diff_sum_r <= '0;
      diff_sq_r  <= '0;
    end else if (accept) begin
      if (in_data.frame_end) begin
        column_r   <= '0;
        row_r      <= '0;
        count_r    <= '0;
        ref_sum_r  <= '0;
        ref_sq_r   <= '0;
        diff_sum_r <= '0;
        diff_sq_r  <= '0;
      end else begin
        column_r   <= column_nxt;
        row_r      <= row_nxt;
        count_r    <= stats.count;
        ref_sum_r  <= stats.ref_sum;
        ref_sq_r   <= stats.ref_square_sum;
        diff_sum_r <= stats.diff_sum;
        diff_sq_r  <= stats.diff_square_sum;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/ies_queue.sv
// Short queue of finished frame records between the front and back ends.
// Depends on ies_pkg for frame_stats_t and the queue depth.
`default_nettype none

module ies_queue
  import ies_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         push_ready,
  input  frame_stats_t push_data,
  output logic         pop_valid,
  input  logic         pop,
  output frame_stats_t pop_data
);

  frame_stats_t         entry_r [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   fill_r;

  assign push_ready = (fill_r != Q_CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];

  // Store pushed records
  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push && push_ready) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop && pop_valid) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      fill_r <= fill_r + Q_CNT_W'(push && push_ready) - Q_CNT_W'(pop && pop_valid);
    end
  end

endmodule

`default_nettype wire

### rtl/ies_back.sv
// Back end: per-frame sequencer with one shared 32x32 multiplier and a
// radix-2 divider, ending in the result register. Depends on ies_pkg.
`default_nettype none

module ies_back
  import ies_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         stats_valid,
  input  frame_stats_t stats,
  output logic         stats_pop,
  output logic         out_valid,
  input  logic         out_ready,
  output out_item_t    out_data
);

  back_state_t        state_r;
  back_state_t        state_nxt;
  pass_t              pass_r;

  logic [CNT_W-1:0]   n_r;
  logic [RSUM_W-1:0]  rsum_r;
  logic [SQ_W-1:0]    rsq_r;
  logic [DABS_W-1:0]  dabs_r;
  logic [SQ_W-1:0]    dsq_r;
  logic [PROD_W-1:0]  prod_r;
  logic [NUM_W-1:0]   num_r;
  logic [DEN_W-1:0]   den_r;
  logic [DEN_W-1:0]   rem_r;
  logic [QUOT_W-1:0]  low_r;
  logic [QUOT_W-1:0]  quot_r;
  logic [STEP_W-1:0]  step_r;
  logic [23:0]        mse_r;
  logic [21:0]        rv_r;
  logic [23:0]        dv_r;
  logic               dzero_r;
  logic               empty_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [DABS_W-1:0]  s1;
  logic [SQ_W-1:0]    s2;
  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [DEN_W:0]     rem_sh;
  logic               rem_ge;
  logic               out_load;
  logic [DSUM_W-1:0]  dsum_neg;

  // Operands of the current variance pass
  assign s1 = (pass_r == PASS_REF) ? rsum_r : dabs_r;
  assign s2 = (pass_r == PASS_REF) ? rsq_r : dsq_r;

  // Shared multiplier
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Divider step: shift in the next dividend bit, subtract when it fits
  assign rem_sh = {rem_r, low_r[QUOT_W-1]};
  assign rem_ge = rem_sh >= (DEN_W+1)'(den_r);

  assign dsum_neg = -stats.diff_sum;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (stats_valid) state_nxt = ST_LOAD;
      ST_LOAD:     state_nxt = (stats.count == '0) ? ST_OUT : ST_MSE_SET;
      ST_MSE_SET:  state_nxt = ST_DIV_INIT;
      ST_MUL_LO:   state_nxt = ST_MUL_HI;
      ST_MUL_HI:   state_nxt = ST_MUL_SQ;
      ST_MUL_SQ:   state_nxt = ST_MUL_NN;
      ST_MUL_NN:   state_nxt = ST_DEN;
      ST_DEN:      state_nxt = ST_DIV_INIT;
      ST_DIV_INIT: state_nxt = ST_DIV_STEP;
      ST_DIV_STEP: if (step_r == STEP_W'(QUOT_W - 1)) state_nxt = ST_STORE;
      ST_STORE:    state_nxt = (pass_r == PASS_DIFF) ? ST_OUT : ST_MUL_LO;
      ST_OUT:      if (out_load) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: queue pop, result load, multiplier operands
  always_comb begin
    stats_pop = 1'b0;
    out_load  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      ST_LOAD: stats_pop = 1'b1;
      ST_MUL_LO: begin
        mul_a = MUL_W'(n_r);
        mul_b = MUL_W'(s2[HALF_W-1:0]);
      end
      ST_MUL_HI: begin
        mul_a = MUL_W'(n_r);
        mul_b = MUL_W'(s2[SQ_W-1:HALF_W]);
      end
      ST_MUL_SQ: begin
        mul_a = s1;
        mul_b = s1;
      end
      ST_MUL_NN: begin
        mul_a = MUL_W'(n_r);
        mul_b = MUL_W'(n_r);
      end
      ST_OUT: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_LOAD: begin
        n_r     <= stats.count;
        rsum_r  <= stats.ref_sum;
        rsq_r   <= stats.ref_square_sum;
        dabs_r  <= stats.diff_sum[DSUM_W-1] ? dsum_neg[DABS_W-1:0]
                                             : stats.diff_sum[DABS_W-1:0];
        dsq_r   <= stats.diff_square_sum;
        pass_r  <= PASS_MSE;
        mse_r   <= '0;
        rv_r    <= '0;
        dv_r    <= '0;
        dzero_r <= 1'b0;
        empty_r <= (stats.count == '0);
      end
      ST_MSE_SET: begin
        num_r <= NUM_W'(dsq_r);
        den_r <= DEN_W'(n_r);
      end
      ST_MUL_LO: prod_r <= mul_p;
      ST_MUL_HI: begin
        prod_r <= mul_p;
        num_r  <= prod_r;
      end
      ST_MUL_SQ: begin
        prod_r <= mul_p;
        num_r  <= num_r + (prod_r << HALF_W);
      end
      ST_MUL_NN: begin
        prod_r <= mul_p;
        num_r  <= num_r - prod_r;
      end
      ST_DEN: den_r <= prod_r[DEN_W-1:0];
      ST_DIV_INIT: begin
        // The scaled dividend is num * 256; its top part is below the divisor
        rem_r  <= DEN_W'(num_r[NUM_W-1:QUOT_W-FRAC_W]);
        low_r  <= {num_r[QUOT_W-FRAC_W-1:0], FRAC_W'(0)};
        quot_r <= '0;
        step_r <= '0;
        if (pass_r == PASS_DIFF) begin
          dzero_r <= (num_r == '0);
        end
      end
      ST_DIV_STEP: begin
        rem_r  <= rem_ge ? DEN_W'(rem_sh - (DEN_W+1)'(den_r)) : rem_sh[DEN_W-1:0];
        low_r  <= low_r << 1;
        quot_r <= {quot_r[QUOT_W-2:0], rem_ge};
        step_r <= step_r + STEP_W'(1);
      end
      ST_STORE: begin
        unique case (pass_r)
          PASS_MSE: begin
            mse_r  <= quot_r;
            pass_r <= PASS_REF;
          end
          PASS_REF: begin
            rv_r   <= quot_r[21:0];
            pass_r <= PASS_DIFF;
          end
          PASS_DIFF: dv_r <= quot_r;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Result register; the next frame starts once a transaction frees it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.mse_q8             <= mse_r;
      out_data_r.ref_variance_q8    <= rv_r;
      out_data_r.diff_variance_q8   <= dv_r;
      out_data_r.diff_variance_zero <= dzero_r;
      out_data_r.empty_window       <= empty_r;
      out_data_r.pixel_count        <= n_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### rtl/ies_checker.sv
// Port-level checks for image_error_statistics_top, attached by bind.
// Depends on ies_pkg for the result type.
`default_nettype none

module ies_checker
  import ies_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // An empty window gives all zeros
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.empty_window |->
      out_data.pixel_count == '0 && out_data.mse_q8 == '0 &&
      out_data.ref_variance_q8 == '0 && out_data.diff_variance_q8 == '0 &&
      !out_data.diff_variance_zero)
    else $error("empty window with nonzero fields");

  // A nonempty window counts between one and the cap
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.empty_window |->
      out_data.pixel_count != '0 && out_data.pixel_count <= COUNT_CAP)
    else $error("pixel count out of range");

  // Zero variance flag agrees with the variance value
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.diff_variance_zero |-> out_data.diff_variance_q8 == '0)
    else $error("zero variance flag with nonzero variance");

endmodule

bind image_error_statistics_top ies_checker u_ies_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

### sim/tb_image_error_statistics_top.sv
// Self-checking testbench for image_error_statistics_top: streams pixel pairs
// through several window settings and checks each frame's statistics.
// Depends on ies_pkg and the RTL under rtl/.
`default_nettype none

module tb_image_error_statistics_top;
  import ies_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 200;
  localparam int IDLE_LIMIT    = 4000;  // cycles without any transaction
  localparam int RANDOM_PIXELS = 500;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;

  image_error_statistics_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Pixels waiting to be sent and frame statistics waiting to come back
  in_item_t  pixel_q[$];
  out_item_t frame_stats_q[$];

  int err_count      = 0;
  int pixels_sent    = 0;
  int frames_checked = 0;
  int settings_used  = 1;
  int random_pixels  = 0;

  // Window registers as the block should hold them
  logic [12:0] frame_w_cfg;
  logic [11:0] left_cfg;
  logic [11:0] top_cfg;
  logic [12:0] right_cfg;
  logic [12:0] bottom_cfg;

  // Raster position and window sums of the frame in progress
  logic [11:0] col_pos;
  logic [11:0] row_pos;
  logic [24:0] win_count;
  logic [63:0] ref_sum_acc;
  logic [63:0] ref_sq_acc;
  logic [63:0] diff_sum_acc;
  logic [63:0] diff_sq_acc;

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d (frame %0d)", what, got, want,
             frames_checked);
    err_count++;
  endtask

  function automatic void clear_sums();
    col_pos      = '0;
    row_pos      = '0;
    win_count    = '0;
    ref_sum_acc  = '0;
    ref_sq_acc   = '0;
    diff_sum_acc = '0;
    diff_sq_acc  = '0;
  endfunction

  // floor(256 * num / den) without losing the high bits
  function automatic logic [63:0] q8_scale(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = num / den;
    rem = num % den;
    return (quo << 8) + ((rem << 8) / den);
  endfunction

  // Fold one accepted pixel into the sums; on frame end queue the statistics
  function automatic void account_pixel(in_item_t px);
    logic [63:0] r_val;
    logic [63:0] t_val;
    logic [63:0] abs_d;
    logic [63:0] n_pix;
    logic [63:0] abs_sum;
    logic [63:0] num_ref;
    logic [63:0] num_diff;
    logic        in_win;
    int          line_w;
    out_item_t   stats;
    r_val = 64'(px.ref_pixel);
    t_val = 64'(px.test_pixel);
    in_win = (col_pos >= left_cfg) && (row_pos >= top_cfg)
          && (right_cfg[12] || {1'b0, col_pos} <= right_cfg)
          && (bottom_cfg[12] || {1'b0, row_pos} <= bottom_cfg);
    // accumulation freezes once the count reaches 2^24
    if (in_win && win_count < 25'h1000000) begin
      abs_d = (t_val >= r_val) ? t_val - r_val : r_val - t_val;
      win_count++;
      ref_sum_acc  += r_val;
      ref_sq_acc   += r_val * r_val;
      diff_sum_acc += t_val - r_val;
      diff_sq_acc  += abs_d * abs_d;
    end
    // advance raster position; zero width acts as one, row saturates
    line_w = int'(frame_w_cfg);
    if (line_w == 0) line_w = 1;
    if (line_w > MAX_WIDTH) line_w = MAX_WIDTH;
    if (int'(col_pos) + 1 >= line_w) begin
      col_pos = '0;
      if (int'(row_pos) + 1 < MAX_HEIGHT) row_pos++;
    end else begin
      col_pos++;
    end
    if (!px.frame_end) return;
    stats = '0;
    if (win_count == 0) begin
      stats.empty_window = 1'b1;
    end else begin
      n_pix    = 64'(win_count);
      abs_sum  = diff_sum_acc[63] ? -diff_sum_acc : diff_sum_acc;
      num_ref  = n_pix * ref_sq_acc - ref_sum_acc * ref_sum_acc;
      num_diff = n_pix * diff_sq_acc - abs_sum * abs_sum;
      stats.mse_q8             = 24'(q8_scale(diff_sq_acc, n_pix));
      stats.ref_variance_q8    = 22'(q8_scale(num_ref, n_pix * n_pix));
      stats.diff_variance_q8   = 24'(q8_scale(num_diff, n_pix * n_pix));
      stats.diff_variance_zero = (num_diff == 0);
      stats.pixel_count        = win_count;
    end
    frame_stats_q.push_back(stats);
    clear_sums();
  endfunction

  // Driver: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        account_pixel(in_data);
        pixels_sent <= pixels_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pixel_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: ready follows a random 16-bit mask, stepped by the low tick bits and redrawn when the tick counter wraps
  logic [15:0] ready_mask = 16'hFFFF;
  logic [5:0]  stall_tick = '0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      stall_tick <= stall_tick + 1'b1;
      if (stall_tick == 6'd63)
        ready_mask <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
      out_ready <= ready_mask[stall_tick[3:0]];
    end
  end

  // Monitor: check each result transaction against the oldest frame
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frame_stats_q.size() == 0) begin
        report("result with no frame pending", out_data.pixel_count, 0);
      end else begin
        want = frame_stats_q.pop_front();
        if (out_data.mse_q8 !== want.mse_q8)
          report("mse_q8", out_data.mse_q8, want.mse_q8);
        if (out_data.ref_variance_q8 !== want.ref_variance_q8)
          report("ref_variance_q8", out_data.ref_variance_q8, want.ref_variance_q8);
        if (out_data.diff_variance_q8 !== want.diff_variance_q8)
          report("diff_variance_q8", out_data.diff_variance_q8, want.diff_variance_q8);
        if (out_data.diff_variance_zero !== want.diff_variance_zero)
          report("diff_variance_zero", out_data.diff_variance_zero,
                 want.diff_variance_zero);
        if (out_data.empty_window !== want.empty_window)
          report("empty_window", out_data.empty_window, want.empty_window);
        if (out_data.pixel_count !== want.pixel_count)
          report("pixel_count", out_data.pixel_count, want.pixel_count);
      end
      frames_checked++;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles, %0d frames still pending",
                 idle_cycles, frame_stats_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_pixel(logic [7:0] r_pix, logic [7:0] t_pix, logic last);
    in_item_t px;
    px.ref_pixel  = r_pix;
    px.test_pixel = t_pix;
    px.frame_end  = last;
    pixel_q.push_back(px);
  endtask

  task automatic push_frame(int len);
    for (int i = 0; i < len; i++)
      push_pixel(rand_pixel(), rand_pixel(), i == len - 1);
  endtask

  // Queue random frames until about total pixels are pending
  task automatic push_frames(int total, int max_len);
    int queued;
    int len;
    queued = 0;
    while (queued < total) begin
      len = $urandom_range(1, max_len);
      push_frame(len);
      queued += len;
    end
    random_pixels += queued;
  endtask

  // Hold until every frame has come back, then let the back end go quiet;
  // sample on the falling edge so the driver's updates have settled
  task automatic wait_idle();
    @(negedge clk);
    while (pixel_q.size() != 0 || in_valid || frame_stats_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_FRAME_WIDTH: frame_w_cfg = val;
      CFG_WIN_LEFT:    left_cfg    = val[11:0];
      CFG_WIN_TOP:     top_cfg     = val[11:0];
      CFG_WIN_RIGHT:   right_cfg   = val;
      CFG_WIN_BOTTOM:  bottom_cfg  = val;
      default: ;
    endcase
  endtask

  task automatic set_window(logic [12:0] width, logic [11:0] left, logic [11:0] top,
                            logic [12:0] right, logic [12:0] bottom);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, width);
    write_reg(CFG_WIN_LEFT, 13'(left));
    write_reg(CFG_WIN_TOP, 13'(top));
    write_reg(CFG_WIN_RIGHT, right);
    write_reg(CFG_WIN_BOTTOM, bottom);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int          width;
    logic [12:0] right;
    logic [12:0] bottom;
    frame_w_cfg = 13'd4096;
    left_cfg    = '0;
    top_cfg     = '0;
    right_cfg   = 13'h1FFF;
    bottom_cfg  = 13'h1FFF;
    clear_sums();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: single-pixel frames at the extremes, then small mixed frames
    push_pixel(8'd0, 8'd255, 1'b1);
    push_pixel(8'd255, 8'd0, 1'b1);
    push_pixel(8'd0, 8'd0, 1'b1);
    push_pixel(8'd255, 8'd255, 1'b1);
    push_pixel(8'd0, 8'd255, 1'b0);
    push_pixel(8'd255, 8'd0, 1'b0);
    push_pixel(8'd0, 8'd0, 1'b0);
    push_pixel(8'd255, 8'd255, 1'b0);
    push_pixel(8'd128, 8'd127, 1'b0);
    push_pixel(8'd1, 8'd254, 1'b1);
    // constant offset: nonzero error but zero difference variance
    push_pixel(8'd10, 8'd20, 1'b0);
    push_pixel(8'd30, 8'd40, 1'b0);
    push_pixel(8'd200, 8'd210, 1'b0);
    push_pixel(8'd55, 8'd65, 1'b1);

    // Random frames under the reset window
    push_frames(60, 30);

    // Zero width acts as one column; rows 2..5 only
    set_window(13'd0, 12'd0, 12'd2, 13'h1FFF, 13'd5);
    push_frames(60, 12);

    // Oversized width clamps; columns 3..10, any negative bottom bound
    set_window(13'd8191, 12'd3, 12'd0, 13'd10, 13'h1800);
    push_frames(60, 20);

    // Window at the far corner: never reached, every frame is empty
    set_window(13'd4096, 12'd4095, 12'd4095, 13'd4095, 13'd4095);
    push_frames(30, 30);

    // One column per row, window from row 3 down to the frame edge
    set_window(13'd1, 12'd0, 12'd3, 13'h1FFF, 13'h1FFF);
    push_frames(30, 10);

    // Random windows until the random budget is spent
    while (random_pixels < RANDOM_PIXELS) begin
      width = ($urandom_range(0, 4) == 0) ? $urandom_range(4096, 8191)
                                          : $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0:       right = 13'h1000 | 13'($urandom_range(0, 4095));
        1:       right = 13'h1FFF;
        default: right = 13'($urandom_range(0, 14));
      endcase
      case ($urandom_range(0, 3))
        0:       bottom = 13'h1000 | 13'($urandom_range(0, 4095));
        1:       bottom = 13'h1FFF;
        default: bottom = 13'($urandom_range(0, 6));
      endcase
      set_window(13'(width), 12'($urandom_range(0, 8)), 12'($urandom_range(0, 3)),
                 right, bottom);
      push_frames(50, (width > 12) ? 40 : 4 * width + 4);
    end

    wait_idle();
    $display("Checked %0d frames from %0d pixels over %0d window settings,",
             frames_checked, pixels_sent, settings_used);
    $display("including empty windows, zero and clamped widths and negative bounds.");
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", err_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/ies_pkg.sv
rtl/ies_front.sv
rtl/ies_queue.sv
rtl/ies_back.sv
rtl/image_error_statistics_top.sv
rtl/ies_checker.sv
sim/tb_image_error_statistics_top.sv
